>>> hdl/prpd_pkg.sv
// ----------------------------------------------------------------------------
// PCX run-length palette decoder package
// Shared widths, constants, register indexes and the controller interface.
// ----------------------------------------------------------------------------
package prpd_pkg;

  localparam int unsigned PalDepth   = 256;
  localparam int unsigned PalAddrW   = $clog2(PalDepth);
  localparam int unsigned ColourW    = 24;
  localparam int unsigned DimW       = 13;
  localparam int unsigned RowOutW    = 12;
  localparam int unsigned RunW       = 6;
  localparam int unsigned InDataW    = 40;
  localparam int unsigned OutDataW   = 64;
  localparam int unsigned CfgIndexW  = 2;

  localparam logic [DimW-1:0]     MaxDim    = 13'd4096;
  localparam logic [7:0]          EscapeMin = 8'hC0;
  localparam logic [7:0]          Opaque    = 8'd255;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] CfgImageWidth  = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgImageHeight = 2'd1;
  localparam logic [CfgIndexW-1:0] CfgLineBytes   = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic accept;     // input transfer completes this cycle
    logic emit_step;  // output transfer completes this cycle
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_run;  // the offered item produces at least one pixel
    logic last_pixel; // the pixel on the output is the last of its run
  } ctrl_status_t;

endpackage

>>> hdl/pcx_rle_palette_decoder.sv
// ----------------------------------------------------------------------------
// PCX run-length palette decoder
// Turns palette writes and 8-bit PCX coded bytes into RGBA pixel transfers.
// ----------------------------------------------------------------------------
// One input transfer is taken at a time. A palette write, an escape byte and
// an ignored byte are each accepted without emitting pixels. A byte that
// yields a run of n pixels is accepted while the palette memory is read, and
// its pixels then follow, one pixel per output transfer. The input is not
// ready while the pixels of a run are being emitted. Registers are to be
// written on the cfg port while the block is idle; the block does not enforce it.
module pcx_rle_palette_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [prpd_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [prpd_pkg::DimW-1:0]      cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: palette_index[7:0], palette_color[31:8], data_byte[39:32]
  input  logic [prpd_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: command
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: pixel_row[11:0], pixel_column[24:12], red[32:25], green[40:33],
  //        blue[48:41], alpha[56:49], zero[63:57]
  output logic [prpd_pkg::OutDataW-1:0]  m_axis_tdata,
  // tlast: run_last
  output logic                           m_axis_tlast,
  // tuser: image_complete
  output logic                           m_axis_tuser
);

  prpd_pkg::ctrl_cmd_t    cmd;
  prpd_pkg::ctrl_status_t status;

  prpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  prpd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_command_i   (s_axis_tuser),
    .in_data_i      (s_axis_tdata),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_data_o     (m_axis_tdata),
    .out_last_o     (m_axis_tlast),
    .out_complete_o (m_axis_tuser)
  );

endmodule

>>> hdl/prpd_ctrl.sv
// ----------------------------------------------------------------------------
// PCX decoder controller
// Two-state machine: takes one input byte at a time, then emits its pixels.
// ----------------------------------------------------------------------------
module prpd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  prpd_pkg::ctrl_status_t status_i,
  output prpd_pkg::ctrl_cmd_t    cmd_o
);

  prpd_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prpd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      prpd_pkg::ST_IDLE: begin
        if (in_valid_i && status_i.start_run) begin
          state_d = prpd_pkg::ST_EMIT;
        end
      end
      prpd_pkg::ST_EMIT: begin
        if (out_ready_i && status_i.last_pixel) begin
          state_d = prpd_pkg::ST_IDLE;
        end
      end
      default: state_d = prpd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      prpd_pkg::ST_IDLE: in_ready_o  = 1'b1;
      prpd_pkg::ST_EMIT: out_valid_o = 1'b1;
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
    cmd_o.accept    = in_ready_o && in_valid_i;
    cmd_o.emit_step = out_valid_o && out_ready_i;
  end

endmodule

>>> hdl/prpd_datapath.sv
// ----------------------------------------------------------------------------
// PCX decoder datapath
// Palette memory, decoder position state, configuration and pixel register.
// ----------------------------------------------------------------------------
module prpd_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [prpd_pkg::CfgIndexW-1:0]         cfg_index_i,
  input  logic [prpd_pkg::DimW-1:0]              cfg_data_i,
  input  logic                                   in_command_i,
  input  logic [prpd_pkg::InDataW-1:0]           in_data_i,
  input  prpd_pkg::ctrl_cmd_t                    cmd_i,
  output prpd_pkg::ctrl_status_t                 status_o,
  output logic [prpd_pkg::OutDataW-1:0]          out_data_o,
  output logic                                   out_last_o,
  output logic                                   out_complete_o
);

  logic [prpd_pkg::DimW-1:0]     height_q, line_bytes_q;
  logic [prpd_pkg::DimW-1:0]     row_q, row_d, col_q, col_d;
  logic                          await_q, await_d;
  logic [prpd_pkg::RunW-1:0]     pend_q, pend_d;
  logic [prpd_pkg::RowOutW-1:0]  out_row_q;
  logic [prpd_pkg::DimW-1:0]     out_col_q;
  logic [prpd_pkg::RunW-1:0]     remain_q;
  logic                          fin_q;
  logic [prpd_pkg::ColourW-1:0]  rd_data_q;
  logic [prpd_pkg::ColourW-1:0]  pal_mem [prpd_pkg::PalDepth];

  logic [prpd_pkg::PalAddrW-1:0] pal_index;
  logic [prpd_pkg::ColourW-1:0]  pal_colour;
  logic [7:0]                    data_byte;
  logic [prpd_pkg::DimW-1:0]     height_eff, len_eff, col_sum, row_inc;
  logic [prpd_pkg::RunW-1:0]     run;
  logic                          active, escape, row_end, finish, img_step;

  assign pal_index  = in_data_i[7:0];
  assign pal_colour = in_data_i[31:8];
  assign data_byte  = in_data_i[39:32];

  // Configuration; image_width has no effect since line_bytes delimits rows.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q     <= prpd_pkg::DimW'(1);
      line_bytes_q <= prpd_pkg::DimW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        prpd_pkg::CfgImageHeight: height_q     <= cfg_data_i;
        prpd_pkg::CfgLineBytes:   line_bytes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    height_eff = (height_q > prpd_pkg::MaxDim) ? prpd_pkg::MaxDim : height_q;
    if (line_bytes_q == '0) begin
      len_eff = prpd_pkg::DimW'(1);
    end else if (line_bytes_q > prpd_pkg::MaxDim) begin
      len_eff = prpd_pkg::MaxDim;
    end else begin
      len_eff = line_bytes_q;
    end
    active   = row_q < height_eff;
    escape   = !await_q && (data_byte >= prpd_pkg::EscapeMin);
    run      = await_q ? pend_q : prpd_pkg::RunW'(1);
    col_sum  = col_q + prpd_pkg::DimW'(run);
    row_end  = col_sum >= len_eff;
    row_inc  = row_q + prpd_pkg::DimW'(1);
    finish   = row_end && (row_inc >= height_eff);
    img_step = in_command_i && active && !escape;

    status_o.start_run  = img_step && (run != '0);
    status_o.last_pixel = remain_q == prpd_pkg::RunW'(1);

    row_d   = row_q;
    col_d   = col_q;
    await_d = await_q;
    pend_d  = pend_q;
    if (cmd_i.accept && in_command_i && active) begin
      if (escape) begin
        await_d = 1'b1;
        pend_d  = data_byte[prpd_pkg::RunW-1:0];
      end else begin
        await_d = 1'b0;
        pend_d  = '0;
        col_d   = row_end ? '0 : col_sum;
        row_d   = row_end ? row_inc : row_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      await_q  <= 1'b0;
      pend_q   <= '0;
      remain_q <= '0;
      fin_q    <= 1'b0;
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      await_q <= await_d;
      pend_q  <= pend_d;
      if (cmd_i.accept && img_step) begin
        remain_q <= run;
        fin_q    <= finish;
      end else if (cmd_i.emit_step) begin
        remain_q <= remain_q - prpd_pkg::RunW'(1);
      end
    end
  end

  // Pixel position of the current output transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && img_step) begin
      out_row_q <= row_q[prpd_pkg::RowOutW-1:0];
      out_col_q <= col_q;
    end else if (cmd_i.emit_step) begin
      out_col_q <= out_col_q + prpd_pkg::DimW'(1);
    end
  end

  // Palette memory: one port, written by palette items, read by image bytes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !in_command_i) begin
      pal_mem[pal_index] <= pal_colour;
    end
    if (cmd_i.accept && img_step) begin
      rd_data_q <= pal_mem[data_byte];
    end
  end

  assign out_data_o = {7'd0, prpd_pkg::Opaque, rd_data_q[7:0], rd_data_q[15:8],
                       rd_data_q[23:16], out_col_q, out_row_q};
  assign out_last_o     = status_o.last_pixel;
  assign out_complete_o = status_o.last_pixel && fin_q;

  a_emit_has_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_step |-> remain_q != '0)
    else $error("pixel emitted with no run remaining");

  a_run_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && status_o.start_run) |=> remain_q != '0)
    else $error("run start did not load a pixel count");

  a_column_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_step |=> out_col_q == $past(out_col_q) + prpd_pkg::DimW'(1))
    else $error("column did not advance by one per pixel");

  a_escape_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && in_command_i && active && escape) |=> await_q)
    else $error("escape byte did not arm the run");

endmodule

>>> tb/tb_pcx_rle_palette_decoder.sv
// ----------------------------------------------------------------------------
// Testbench for the PCX run-length palette decoder
// A short table of hand-picked transfers opens the run: palette extremes,
// escapes with runs of zero and sixty-three, palette writes inside a run,
// registers at and beyond their limits, line length lowered mid-row and bytes
// after the final row. Random coded streams follow under four idling patterns.
// Every pixel transfer is checked against a behavioural decoder kept here.
// ----------------------------------------------------------------------------
module tb_pcx_rle_palette_decoder;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit  = 4000;
  localparam int SettleGap   = 8;
  localparam int ItemsPerPhase = 90;
  localparam int SegmentItems  = 60;

  typedef enum bit {
    CMD_PALETTE,
    CMD_IMAGE
  } cmd_e;

  typedef enum logic [1:0] {
    DIR_REG,
    DIR_PAL,
    DIR_BYTE
  } dir_kind_e;

  typedef struct packed {
    logic [prpd_pkg::RowOutW-1:0] row;
    logic [prpd_pkg::DimW-1:0]    col;
    logic [7:0]                   red;
    logic [7:0]                   green;
    logic [7:0]                   blue;
    logic [7:0]                   alpha;
    logic                         last;
    logic                         done;
  } pixel_t;

  typedef struct {
    dir_kind_e   kind;
    logic [12:0] arg;
    logic [23:0] value;
    bit          typed;
    pixel_t      want;
  } dir_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [prpd_pkg::CfgIndexW-1:0] cfg_index_i = '0;
  logic [prpd_pkg::DimW-1:0]      cfg_data_i = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  // palette_index[7:0], palette_color[31:8], data_byte[39:32]
  logic [prpd_pkg::InDataW-1:0]   s_axis_tdata = '0;
  // command
  logic                           s_axis_tuser = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // pixel_row[11:0], pixel_column[24:12], red[32:25], green[40:33],
  // blue[48:41], alpha[56:49], zero[63:57]
  logic [prpd_pkg::OutDataW-1:0]  m_axis_tdata;
  logic                           m_axis_tlast;  // run_last
  logic                           m_axis_tuser;  // image_complete

  pcx_rle_palette_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // Decoder state as the block should hold it.
  logic [prpd_pkg::ColourW-1:0] pal_mem [prpd_pkg::PalDepth];
  bit                           pal_written [prpd_pkg::PalDepth];
  logic [prpd_pkg::DimW-1:0]    exp_row;
  logic [prpd_pkg::DimW-1:0]    exp_col;
  bit                           run_armed;
  logic [prpd_pkg::RunW-1:0]    armed_len;
  logic [prpd_pkg::DimW-1:0]    reg_height;
  logic [prpd_pkg::DimW-1:0]    reg_line;

  pixel_t   pending_pixels [$];
  dir_row_t dir_rows [$];
  int       n_predicted;
  int       n_decoded;
  int       n_fail;
  int       send_idle;
  int       recv_stall;
  int       quiet_cycles;

  function automatic int height_limit();
    return (reg_height > prpd_pkg::MaxDim) ? int'(prpd_pkg::MaxDim) : int'(reg_height);
  endfunction

  function automatic int line_limit();
    if (reg_line == '0) begin
      return 1;
    end
    return (reg_line > prpd_pkg::MaxDim) ? int'(prpd_pkg::MaxDim) : int'(reg_line);
  endfunction

  // Works out the pixels that one accepted input transfer must produce.
  task automatic predict_pixels(input cmd_e cmd, input logic [7:0] idx,
                                input logic [23:0] colour, input logic [7:0] dbyte);
    int                        run;
    logic [prpd_pkg::DimW-1:0] row0;
    logic [prpd_pkg::DimW-1:0] col0;
    bit                        done;
    logic [23:0]               c;
    pixel_t                    px;
    if (cmd == CMD_PALETTE) begin
      pal_mem[idx]     = colour;
      pal_written[idx] = 1'b1;
      n_decoded++;
      return;
    end
    if (exp_row >= height_limit()) begin
      return;
    end
    n_decoded++;
    if (!run_armed && dbyte >= prpd_pkg::EscapeMin) begin
      run_armed = 1'b1;
      armed_len = dbyte[prpd_pkg::RunW-1:0];
      return;
    end
    run       = run_armed ? int'(armed_len) : 1;
    run_armed = 1'b0;
    armed_len = '0;
    row0      = exp_row;
    col0      = exp_col;
    done      = 1'b0;
    exp_col   = exp_col + prpd_pkg::DimW'(run);
    if (exp_col >= line_limit()) begin
      exp_col = '0;
      exp_row = exp_row + prpd_pkg::DimW'(1);
      done    = (exp_row >= height_limit());
    end
    c = pal_mem[dbyte];
    for (int k = 0; k < run; k++) begin
      px.row   = row0[prpd_pkg::RowOutW-1:0];
      px.col   = col0 + prpd_pkg::DimW'(k);
      px.red   = c[23:16];
      px.green = c[15:8];
      px.blue  = c[7:0];
      px.alpha = prpd_pkg::Opaque;
      px.last  = (k + 1 == run);
      px.done  = (k + 1 == run) && done;
      pending_pixels.push_back(px);
      n_predicted++;
    end
  endtask

  task automatic send_item(input cmd_e cmd, input logic [7:0] idx,
                           input logic [23:0] colour, input logic [7:0] dbyte);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {dbyte, colour, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pixels(cmd, idx, colour, dbyte);
  endtask

  task automatic send_palette(input logic [7:0] idx, input logic [23:0] colour);
    send_item(CMD_PALETTE, idx, colour, 8'($urandom()));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(CMD_IMAGE, 8'($urandom()), 24'($urandom()), b);
  endtask

  // A colour index is only sent once its palette entry holds a value.
  task automatic send_colour_index(input logic [7:0] b);
    if (!pal_written[b]) begin
      send_palette(b, 24'($urandom()));
    end
    send_byte(b);
  endtask

  // Lets every outstanding pixel drain, then idles so that a run of zero settles.
  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleGap) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [prpd_pkg::CfgIndexW-1:0] idx,
                           input logic [prpd_pkg::DimW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      prpd_pkg::CfgImageHeight: reg_height = val;
      prpd_pkg::CfgLineBytes:   reg_line   = val;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_step();
    int          pick;
    int          len;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_palette(8'($urandom()), 24'($urandom()));
    end else if (run_armed) begin
      send_colour_index(8'($urandom_range(255)));
    end else if (pick < 50) begin
      case ($urandom_range(9))
        0:       len = 0;
        1:       len = 63;
        default: len = $urandom_range(1, 62);
      endcase
      b = prpd_pkg::EscapeMin | 8'(len);
      send_byte(b);
    end else begin
      send_colour_index(8'($urandom_range(prpd_pkg::EscapeMin - 1)));
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned seen);
    if (want != seen) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
      n_fail++;
    end
  endtask

  task automatic add_row(input dir_kind_e kind, input int arg, input int value,
                         input bit typed = 1'b0, input int erow = 0, input int ecol = 0,
                         input int ecolour = 0, input bit edone = 1'b0);
    dir_row_t r;
    r.kind       = kind;
    r.arg        = 13'(arg);
    r.value      = 24'(value);
    r.typed      = typed;
    r.want.row   = prpd_pkg::RowOutW'(erow);
    r.want.col   = prpd_pkg::DimW'(ecol);
    r.want.red   = 8'(ecolour >> 16);
    r.want.green = 8'(ecolour >> 8);
    r.want.blue  = 8'(ecolour);
    r.want.alpha = prpd_pkg::Opaque;
    r.want.last  = 1'b1;
    r.want.done  = edone;
    dir_rows.push_back(r);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk_i) begin : pixel_monitor
    pixel_t seen;
    pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.row   = m_axis_tdata[11:0];
      seen.col   = m_axis_tdata[24:12];
      seen.red   = m_axis_tdata[32:25];
      seen.green = m_axis_tdata[40:33];
      seen.blue  = m_axis_tdata[48:41];
      seen.alpha = m_axis_tdata[56:49];
      seen.last  = m_axis_tlast;
      seen.done  = m_axis_tuser;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel transfer, expected none, actual %h", $time, seen);
        n_fail++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_row", want.row, seen.row);
        check_field("pixel_column", want.col, seen.col);
        check_field("red", want.red, seen.red);
        check_field("green", want.green, seen.green);
        check_field("blue", want.blue, seen.blue);
        check_field("alpha", want.alpha, seen.alpha);
        check_field("padding", 0, m_axis_tdata[63:57]);
        check_field("run_last", want.last, seen.last);
        check_field("image_complete", want.done, seen.done);
      end
    end
  end

  // Stops a hung run: counts cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n0;
    int goal;
    int hgt;
    n_predicted  = 0;
    n_decoded    = 0;
    n_fail       = 0;
    send_idle    = 0;
    recv_stall   = 0;
    exp_row      = '0;
    exp_col      = '0;
    run_armed    = 1'b0;
    armed_len    = '0;
    reg_height   = 13'd1;
    reg_line     = 13'd1;
    foreach (pal_written[i]) begin
      pal_written[i] = 1'b0;
      pal_mem[i]     = '0;
    end

    add_row(DIR_PAL, 'h00, 'h000000);
    add_row(DIR_PAL, 'hFF, 'hFFFFFF);
    add_row(DIR_PAL, 'hBF, 'h123456);
    add_row(DIR_PAL, 'hC0, 'hA5C3E1);
    add_row(DIR_PAL, 'h01, 'h5A3C1E);
    // With the reset registers a single literal completes the image.
    add_row(DIR_BYTE, 0, 'h01, 1'b1, 0, 0, 'h5A3C1E, 1'b1);
    add_row(DIR_BYTE, 0, 'h00);
    add_row(DIR_REG, int'(prpd_pkg::CfgImageWidth), 0);
    add_row(DIR_REG, int'(prpd_pkg::CfgImageHeight), 3);
    add_row(DIR_REG, int'(prpd_pkg::CfgLineBytes), 0);
    // Longest run, then a run of zero, then a literal that ends the image.
    add_row(DIR_BYTE, 0, 'hFF);
    add_row(DIR_BYTE, 0, 'hC0);
    add_row(DIR_BYTE, 0, 'hC0);
    add_row(DIR_BYTE, 0, 'h00);
    add_row(DIR_BYTE, 0, 'hBF, 1'b1, 2, 0, 'h123456, 1'b1);
    add_row(DIR_BYTE, 0, 'hFF);
    add_row(DIR_REG, int'(prpd_pkg::CfgImageHeight), 8191);
    add_row(DIR_REG, int'(prpd_pkg::CfgLineBytes), 4096);
    add_row(DIR_REG, int'(prpd_pkg::CfgImageWidth), 8191);
    add_row(DIR_BYTE, 0, 'hC1);
    add_row(DIR_BYTE, 0, 'hFF, 1'b1, 3, 0, 'hFFFFFF, 1'b0);
    // A palette write between an escape and its value byte.
    add_row(DIR_BYTE, 0, 'hC2);
    add_row(DIR_PAL, 'h00, 'h0F0F0F);
    add_row(DIR_BYTE, 0, 'h00);
    // Line length dropped below the current column: the next byte ends the row.
    add_row(DIR_REG, int'(prpd_pkg::CfgLineBytes), 1);
    add_row(DIR_BYTE, 0, 'h01, 1'b1, 3, 3, 'h5A3C1E, 1'b0);
    add_row(DIR_REG, int'(prpd_pkg::CfgLineBytes), 8191);
    add_row(DIR_BYTE, 0, 'h01);
    add_row(DIR_BYTE, 0, 'h01);
    // A run of zero that closes the final row produces nothing.
    add_row(DIR_REG, int'(prpd_pkg::CfgImageHeight), 5);
    add_row(DIR_REG, int'(prpd_pkg::CfgLineBytes), 1);
    add_row(DIR_BYTE, 0, 'hC0);
    add_row(DIR_BYTE, 0, 'h00);
    add_row(DIR_BYTE, 0, 'h01);
    add_row(DIR_REG, int'(prpd_pkg::CfgImageHeight), 0);
    add_row(DIR_BYTE, 0, 'h01);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        DIR_REG: begin
          go_idle();
          write_reg(dir_rows[i].arg[prpd_pkg::CfgIndexW-1:0], dir_rows[i].value[12:0]);
        end
        DIR_PAL: begin
          send_palette(dir_rows[i].arg[7:0], dir_rows[i].value);
        end
        default: begin
          n0 = n_predicted;
          send_byte(dir_rows[i].value[7:0]);
          if (dir_rows[i].typed) begin
            if (n_predicted == n0 + 1) begin
              void'(pending_pixels.pop_back());
            end
            pending_pixels.push_back(dir_rows[i].want);
          end
        end
      endcase
    end

    goal = n_decoded;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 87; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 87; end
        default: begin send_idle = 37; recv_stall = 37; end
      endcase
      goal += ItemsPerPhase;
      while (n_decoded < goal) begin
        go_idle();
        write_reg(prpd_pkg::CfgImageWidth, prpd_pkg::DimW'($urandom()));
        case ($urandom_range(9))
          0:       write_reg(prpd_pkg::CfgLineBytes, 13'd0);
          1:       write_reg(prpd_pkg::CfgLineBytes, 13'd8191);
          2:       write_reg(prpd_pkg::CfgLineBytes, 13'd4096);
          default: write_reg(prpd_pkg::CfgLineBytes, prpd_pkg::DimW'($urandom_range(1, 24)));
        endcase
        hgt = int'(exp_row) + $urandom_range(1, 8);
        if ($urandom_range(9) == 0) begin
          write_reg(prpd_pkg::CfgImageHeight, 13'd8191);
        end else begin
          write_reg(prpd_pkg::CfgImageHeight,
                    prpd_pkg::DimW'((hgt > int'(prpd_pkg::MaxDim)) ?
                                    int'(prpd_pkg::MaxDim) : hgt));
        end
        for (int n = 0; n < SegmentItems; n++) begin
          if (exp_row >= height_limit() || n_decoded >= goal) begin
            break;
          end
          random_step();
        end
        // Trailing bytes once the image is complete are dropped by the block.
        if (exp_row >= height_limit()) begin
          repeat ($urandom_range(1, 2)) send_byte(8'($urandom()));
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4 * SettleGap) @(posedge clk_i);
    if (pending_pixels.size() != 0) begin
      $display("%0t: %0d expected pixels never arrived", $time, pending_pixels.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/prpd_pkg.sv
hdl/prpd_ctrl.sv
hdl/prpd_datapath.sv
hdl/pcx_rle_palette_decoder.sv
tb/tb_pcx_rle_palette_decoder.sv
